// File: rtl/scheduled_motor_run_controller_defines.svh
// Assertion macros shared by the controller RTL.
`ifndef SCHEDULED_MOTOR_RUN_CONTROLLER_DEFINES_SVH
`define SCHEDULED_MOTOR_RUN_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SMRC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("smrc same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SMRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("smrc next-cycle check failed");

`endif

// File: rtl/smrc_pkg.sv
package smrc_pkg;

    // Default number of schedule windows.
    localparam int WindowsDef = 3;
    // The register map never holds more than three windows.
    localparam int WindowsMax = 3;

    // Field widths.
    localparam int SEC_W = 17;  // second of the day, window ends included
    localparam int CNT_W = 14;  // run countdown in seconds
    localparam int CFG_W = 24;  // one window register

    // Timing constants in milliseconds.
    localparam logic [31:0] HoldMs = 32'd2000;
    localparam logic [31:0] TickMs = 32'd1000;

    // Owner code for a manual run or no run.
    localparam logic [1:0] NoWindow = 2'd3;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_WINDOW_A = 3'd0,
        REG_WINDOW_B = 3'd1,
        REG_WINDOW_C = 3'd2,
        REG_WINDOW_COUNT = 3'd3,
        REG_MANUAL_MINUTES = 3'd4
    } reg_idx_t;

    // Countdown reload from the manual run length; out-of-range lengths mean 30 minutes.
    function automatic logic [CNT_W-1:0] reload_secs(input logic [7:0] minutes);
        logic [7:0] m;
        m = minutes;
        if (m == 8'd0 || m > 8'd240) begin
            m = 8'd30;
        end
        return CNT_W'(m) * CNT_W'(60);
    endfunction

    // Start second of a window; an hour or minute out of range reads as zero.
    function automatic logic [SEC_W-1:0] win_start(input logic [CFG_W-1:0] cfg);
        logic [7:0] h;
        logic [7:0] m;
        h = cfg[7:0];
        m = cfg[15:8];
        if (h > 8'd23) begin
            h = 8'd0;
        end
        if (m > 8'd59) begin
            m = 8'd0;
        end
        return SEC_W'(h) * SEC_W'(3600) + SEC_W'(m) * SEC_W'(60);
    endfunction

    // Length of a window in seconds; out-of-range durations mean 30 minutes.
    function automatic logic [SEC_W-1:0] win_length(input logic [CFG_W-1:0] cfg);
        logic [7:0] d;
        d = cfg[23:16];
        if (d == 8'd0 || d > 8'd240) begin
            d = 8'd30;
        end
        return SEC_W'(d) * SEC_W'(60);
    endfunction

endpackage

// File: rtl/scheduled_motor_run_controller.sv
// Scheduled motor run controller. Each input word is one control pass: a millisecond
// stamp, the over-temperature line, the button level, the wall-clock hour and minute
// and the link state. Each pass yields exactly one result word. One word is accepted
// per clock cycle while not stalled; a word waits in the input register and its
// result is registered into the output register as that register frees. The output
// register lets the input side keep accepting while a result waits, and the block
// stalls only when both registers are full and m_tready is low. Configuration goes
// through the APB port at byte address 4*index and must be written while no pass
// is in flight.
`include "scheduled_motor_run_controller_defines.svh"

module scheduled_motor_run_controller #(
    parameter int WINDOWS = smrc_pkg::WindowsDef
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] now_ms, [32] overtemp_low, [33] button_level, [38:34] clock_hour,
    // [44:39] clock_minute, [45] link_up, [47:46] zero
    input  logic [47:0] s_tdata,

    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] motor_on, [14:1] seconds_left, [16:15] running_window, [17] manual_active,
    // [18] run_changed, [23:19] zero
    output logic [23:0] m_tdata,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import smrc_pkg::*;

    // Windows that the register map can reach.
    localparam int USED = (WINDOWS < WindowsMax) ? WINDOWS : WindowsMax;

    // Configuration registers.
    logic [CFG_W-1:0] win_cfg_reg [USED];
    logic [1:0]       win_count_reg;
    logic [7:0]       manual_min_reg;

    // Pipeline registers.
    logic        in_valid_reg;
    logic [47:0] in_data_reg;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic [23:0] out_data_next;
    logic        advance;

    // Controller state.
    logic             running_reg, running_next;
    logic [CNT_W-1:0] countdown_reg, countdown_next;
    logic [1:0]       owner_reg, owner_next;
    logic [USED-1:0]  done_reg, done_next;
    logic [USED-1:0]  blocked_reg, blocked_next;
    logic             manual_reg, manual_next;
    logic             link_seen_reg, link_seen_next;
    logic             button_prev_reg, button_prev_next;
    logic             ot_valid_reg, ot_valid_next;
    logic [31:0]      ot_since_reg, ot_since_next;
    logic [31:0]      last_sec_reg, last_sec_next;
    logic             running_prev_reg;

    // Fields of the word in the input register.
    logic [31:0]      now_ms;
    logic             overtemp_low;
    logic             button_level;
    logic [4:0]       clock_hour;
    logic [5:0]       clock_minute;
    logic             link_up;
    logic [SEC_W-1:0] now_sec;

    // Derived configuration.
    logic [SEC_W-1:0] win_start_s [USED];
    logic [SEC_W-1:0] win_end_s [USED];
    logic [1:0]       n_eff;
    logic [CNT_W-1:0] reload;

    // Window search results.
    logic             hit;
    logic [1:0]       hit_idx;
    logic [SEC_W-1:0] hit_end;

    // Configuration access.
    logic     cfg_write;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < USED; i++) begin
                win_cfg_reg[i] <= '0;
            end
            win_count_reg  <= 2'd0;
            manual_min_reg <= 8'd30;
        end else if (cfg_write) begin
            unique case (cfg_idx) inside
                REG_WINDOW_A, REG_WINDOW_B, REG_WINDOW_C: begin
                    for (int i = 0; i < USED; i++) begin
                        if (paddr[4:2] == 3'(i)) begin
                            win_cfg_reg[i] <= pwdata[CFG_W-1:0];
                        end
                    end
                end
                REG_WINDOW_COUNT:   win_count_reg  <= pwdata[1:0];
                REG_MANUAL_MINUTES: manual_min_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        prdata = '0;
        unique case (cfg_idx) inside
            REG_WINDOW_A, REG_WINDOW_B, REG_WINDOW_C: begin
                for (int i = 0; i < USED; i++) begin
                    if (paddr[4:2] == 3'(i)) begin
                        prdata = 32'(win_cfg_reg[i]);
                    end
                end
            end
            REG_WINDOW_COUNT:   prdata = 32'(win_count_reg);
            REG_MANUAL_MINUTES: prdata = 32'(manual_min_reg);
            default:            prdata = '0;
        endcase
    end

    // Window spans and the effective window count.
    always_comb begin
        for (int i = 0; i < USED; i++) begin
            win_start_s[i] = win_start(win_cfg_reg[i]);
            win_end_s[i]   = win_start_s[i] + win_length(win_cfg_reg[i]);
        end
        n_eff = (win_count_reg > 2'(USED)) ? 2'(USED) : win_count_reg;
    end

    assign reload = reload_secs(manual_min_reg);

    // Input word fields.
    assign now_ms       = in_data_reg[31:0];
    assign overtemp_low = in_data_reg[32];
    assign button_level = in_data_reg[33];
    assign clock_hour   = in_data_reg[38:34];
    assign clock_minute = in_data_reg[44:39];
    assign link_up      = in_data_reg[45];
    assign now_sec      = SEC_W'(clock_hour) * SEC_W'(3600) + SEC_W'(clock_minute) * SEC_W'(60);

    // The first active window that contains the current second.
    always_comb begin
        hit     = 1'b0;
        hit_idx = NoWindow;
        hit_end = '0;
        for (int i = 0; i < USED; i++) begin
            if (!hit && 2'(i) < n_eff && now_sec >= win_start_s[i] && now_sec < win_end_s[i])
            begin
                hit     = 1'b1;
                hit_idx = 2'(i);
                hit_end = win_end_s[i];
            end
        end
    end

    // Handshake: the pass in the input register moves on when the output register frees.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // One control pass, rules applied in order.
    always_comb begin
        running_next     = running_reg;
        countdown_next   = countdown_reg;
        owner_next       = owner_reg;
        done_next        = done_reg;
        blocked_next     = blocked_reg;
        manual_next      = manual_reg;
        link_seen_next   = link_seen_reg;
        ot_valid_next    = ot_valid_reg;
        ot_since_next    = ot_since_reg;
        last_sec_next    = last_sec_reg;
        button_prev_next = button_level;

        // Over-temperature held for the hold time stops the run and blocks its window.
        if (overtemp_low) begin
            if (!ot_valid_next) begin
                ot_valid_next = 1'b1;
                ot_since_next = now_ms;
            end
            if (now_ms - ot_since_next >= HoldMs) begin
                running_next   = 1'b0;
                countdown_next = reload;
                for (int i = 0; i < USED; i++) begin
                    if (owner_next == 2'(i)) begin
                        done_next[i]    = 1'b1;
                        blocked_next[i] = 1'b1;
                    end
                end
                owner_next    = NoWindow;
                ot_valid_next = 1'b0;
                ot_since_next = '0;
            end
        end else begin
            ot_valid_next = 1'b0;
            ot_since_next = '0;
        end

        // A button press toggles a manual run.
        if (button_prev_reg && !button_level) begin
            if (!running_next) begin
                running_next   = 1'b1;
                countdown_next = reload;
                owner_next     = NoWindow;
            end else begin
                running_next   = 1'b0;
                countdown_next = reload;
                for (int i = 0; i < USED; i++) begin
                    if (owner_next == 2'(i)) begin
                        done_next[i]    = 1'b1;
                        blocked_next[i] = 1'b1;
                    end
                end
                owner_next = NoWindow;
            end
            manual_next = 1'b1;
        end

        // A rising link returns to automatic mode.
        if (link_up && !link_seen_reg) begin
            link_seen_next = 1'b1;
            manual_next    = 1'b0;
        end else if (!link_up && link_seen_reg) begin
            link_seen_next = 1'b0;
        end

        // Flags of a window clear once its end has passed.
        for (int i = 0; i < USED; i++) begin
            if (2'(i) < n_eff && now_sec >= win_end_s[i]) begin
                done_next[i]    = 1'b0;
                blocked_next[i] = 1'b0;
            end
        end

        // Automatic start for the rest of a fresh window.
        if (!manual_next && hit && !running_next) begin
            for (int i = 0; i < USED; i++) begin
                if (hit_idx == 2'(i) && !done_next[i] && !blocked_next[i]) begin
                    running_next   = 1'b1;
                    countdown_next = CNT_W'(hit_end - now_sec);
                    owner_next     = hit_idx;
                    done_next[i]   = 1'b1;
                end
            end
        end

        // Seconds countdown while running; reaching zero stops without blocking.
        if (running_next) begin
            if (now_ms - last_sec_reg >= TickMs) begin
                last_sec_next = now_ms;
                if (countdown_next != '0) begin
                    countdown_next = countdown_next - CNT_W'(1);
                end
            end
            if (countdown_next == '0) begin
                running_next   = 1'b0;
                countdown_next = reload;
                for (int i = 0; i < USED; i++) begin
                    if (owner_next == 2'(i)) begin
                        done_next[i] = 1'b1;
                    end
                end
                owner_next = NoWindow;
            end
        end

        out_data_next = {5'd0, running_next != running_prev_reg, manual_next, owner_next,
                         countdown_next, running_next};
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            running_reg      <= 1'b0;
            countdown_reg    <= CNT_W'(1800);
            owner_reg        <= NoWindow;
            done_reg         <= '0;
            blocked_reg      <= '0;
            manual_reg       <= 1'b1;
            link_seen_reg    <= 1'b0;
            button_prev_reg  <= 1'b1;
            ot_valid_reg     <= 1'b0;
            ot_since_reg     <= '0;
            last_sec_reg     <= '0;
            running_prev_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg    <= 1'b1;
                running_reg      <= running_next;
                countdown_reg    <= countdown_next;
                owner_reg        <= owner_next;
                done_reg         <= done_next;
                blocked_reg      <= blocked_next;
                manual_reg       <= manual_next;
                link_seen_reg    <= link_seen_next;
                button_prev_reg  <= button_prev_next;
                ot_valid_reg     <= ot_valid_next;
                ot_since_reg     <= ot_since_next;
                last_sec_reg     <= last_sec_next;
                running_prev_reg <= running_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // A stopped motor is owned by no window.
    `SMRC_ASSERT_NOW(a_idle_no_owner, aclk, aresetn, !running_reg, owner_reg == NoWindow)
    // A running motor always reports time left.
    `SMRC_ASSERT_NOW(a_run_has_time, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[14:1] != '0)
    // A pass that moves on always leaves a result word behind.
    `SMRC_ASSERT_NEXT(a_advance_result, aclk, aresetn, advance, m_tvalid)

endmodule

// File: verif/scheduled_motor_run_controller_test.sv
module scheduled_motor_run_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smrc_pkg::*;

    localparam int QuietLimit = 1000;
    localparam int LongHoldCycles = 40;
    localparam int DrainCycles = 10;
    localparam int NumWindows = WindowsDef;

    // One control pass as it travels on s_tdata, lowest field last.
    typedef struct packed {
        logic [1:0]  pad;
        logic        link_up;
        logic [5:0]  clock_minute;
        logic [4:0]  clock_hour;
        logic        button_level;
        logic        overtemp_low;
        logic [31:0] now_ms;
    } pass_t;

    // One result word as it travels on m_tdata, lowest field last.
    typedef struct packed {
        logic [4:0]  pad;
        logic        run_changed;
        logic        manual_active;
        logic [1:0]  running_window;
        logic [13:0] seconds_left;
        logic        motor_on;
    } run_status_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    // [31:0] now_ms, [32] overtemp_low, [33] button_level, [38:34] clock_hour,
    // [44:39] clock_minute, [45] link_up, [47:46] zero
    logic [47:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    // [0] motor_on, [14:1] seconds_left, [16:15] running_window, [17] manual_active,
    // [18] run_changed, [23:19] zero
    wire  [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    scheduled_motor_run_controller DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow of the schedule registers.
    logic [23:0] win_cfg [NumWindows];
    logic [1:0]  win_count;
    logic [7:0]  run_minutes;

    // Controller state as the predictor tracks it.
    bit          run_on;
    int unsigned run_secs;
    logic [1:0]  run_owner;
    bit          win_done [NumWindows];
    bit          win_blocked [NumWindows];
    bit          manual_mode;
    bit          link_prev;
    bit          button_prev_lvl;
    logic [31:0] ot_start;
    bit          ot_armed;
    logic [31:0] tick_stamp;
    bit          run_on_prev;

    pass_t       pending_words [$];
    run_status_t expected_status [$];
    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          tx_gap = 0;
    int          rx_stall = 0;
    int          long_holds_req = 0;
    int          long_holds_done = 0;
    bit          idle_off = 1'b0;

    // Stimulus generator state: the plant as seen by the controller.
    logic [31:0] gen_ms;
    logic [4:0]  gen_hour;
    logic [5:0]  gen_min;
    bit          gen_btn;
    bit          gen_link;
    int          gen_ot_left;

    function automatic int unsigned reload_of(input logic [7:0] minutes);
        if (minutes == 8'd0 || minutes > 8'd240) begin
            return 30 * 60;
        end
        return int'(minutes) * 60;
    endfunction

    // Opening and closing second of a schedule; raw fields out of range fall back.
    function automatic void window_bounds(input logic [23:0] cfg, output int unsigned win_open,
                                          output int unsigned win_close);
        int unsigned hr;
        int unsigned mn;
        int unsigned dur;
        hr = 32'(cfg[7:0]);
        mn = 32'(cfg[15:8]);
        dur = 32'(cfg[23:16]);
        if (hr > 23) hr = 0;
        if (mn > 59) mn = 0;
        if (dur < 1 || dur > 240) dur = 30;
        win_open = hr * 3600 + mn * 60;
        win_close = win_open + dur * 60;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < NumWindows; i++) begin
            win_cfg[i] = '0;
            win_done[i] = 1'b0;
            win_blocked[i] = 1'b0;
        end
        win_count = 2'd0;
        run_minutes = 8'd30;
        run_on = 1'b0;
        run_secs = 1800;
        run_owner = NoWindow;
        manual_mode = 1'b1;
        link_prev = 1'b0;
        button_prev_lvl = 1'b1;
        ot_start = '0;
        ot_armed = 1'b0;
        tick_stamp = '0;
        run_on_prev = 1'b0;
    endfunction

    // Stop the motor; the owning schedule is marked done, and blocked if asked.
    function automatic void stop_run(input bit block);
        run_on = 1'b0;
        run_secs = reload_of(run_minutes);
        if (run_owner != NoWindow) begin
            win_done[run_owner] = 1'b1;
            if (block) win_blocked[run_owner] = 1'b1;
        end
        run_owner = NoWindow;
    endfunction

    // One control pass: updates the tracked state and returns the status word.
    function automatic run_status_t control_pass(input pass_t p);
        run_status_t r;
        int unsigned lim;
        int unsigned now_sec;
        int unsigned wo;
        int unsigned wc;
        int unsigned hit;
        int unsigned hit_close;
        lim = 32'(win_count);
        if (lim > NumWindows) lim = NumWindows;
        now_sec = int'(p.clock_hour) * 3600 + int'(p.clock_minute) * 60;
        hit = lim;
        hit_close = 0;

        // Over-temperature hold.
        if (p.overtemp_low) begin
            if (!ot_armed) begin
                ot_armed = 1'b1;
                ot_start = p.now_ms;
            end
            if (p.now_ms - ot_start >= HoldMs) begin
                stop_run(1'b1);
                ot_armed = 1'b0;
                ot_start = '0;
            end
        end else begin
            ot_armed = 1'b0;
            ot_start = '0;
        end

        // Button falling edge toggles a manual run.
        if (button_prev_lvl && !p.button_level) begin
            if (!run_on) begin
                run_on = 1'b1;
                run_secs = reload_of(run_minutes);
                run_owner = NoWindow;
            end else begin
                stop_run(1'b1);
            end
            manual_mode = 1'b1;
        end
        button_prev_lvl = p.button_level;

        // A rising link leaves manual mode.
        if (p.link_up && !link_prev) begin
            link_prev = 1'b1;
            manual_mode = 1'b0;
        end else if (!p.link_up && link_prev) begin
            link_prev = 1'b0;
        end

        // Flags clear once the clock is past a schedule's end.
        for (int i = 0; i < lim; i++) begin
            window_bounds(win_cfg[i], wo, wc);
            if (now_sec >= wc) begin
                win_done[i] = 1'b0;
                win_blocked[i] = 1'b0;
            end
        end

        // Automatic start from the first schedule containing the current time.
        if (!manual_mode) begin
            for (int i = 0; i < lim; i++) begin
                window_bounds(win_cfg[i], wo, wc);
                if (hit == lim && now_sec >= wo && now_sec < wc) begin
                    hit = i;
                    hit_close = wc;
                end
            end
            if (hit < lim && !win_done[hit] && !win_blocked[hit] && !run_on) begin
                run_on = 1'b1;
                run_secs = hit_close - now_sec;
                run_owner = 2'(hit);
                win_done[hit] = 1'b1;
            end
        end

        // One-second countdown while running.
        if (run_on) begin
            if (p.now_ms - tick_stamp >= TickMs) begin
                tick_stamp = p.now_ms;
                if (run_secs > 0) run_secs--;
            end
            if (run_secs == 0) stop_run(1'b0);
        end

        r = '0;
        r.motor_on = run_on;
        r.seconds_left = 14'(run_secs);
        r.running_window = run_owner;
        r.manual_active = manual_mode;
        r.run_changed = (run_on != run_on_prev);
        run_on_prev = run_on;
        return r;
    endfunction

    function automatic void report_field(input string name, input int unsigned want,
                                         input int unsigned got);
        fail_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endfunction

    function automatic void check_status(input run_status_t got);
        run_status_t want;
        if (expected_status.size() == 0) begin
            fail_count++;
            $display("%0t ns: result word with none expected, expected none, actual %h",
                     $time, got);
        end else begin
            want = expected_status.pop_front();
            if (got.motor_on !== want.motor_on)
                report_field("motor_on", 32'(want.motor_on), 32'(got.motor_on));
            if (got.seconds_left !== want.seconds_left)
                report_field("seconds_left", 32'(want.seconds_left), 32'(got.seconds_left));
            if (got.running_window !== want.running_window)
                report_field("running_window", 32'(want.running_window),
                             32'(got.running_window));
            if (got.manual_active !== want.manual_active)
                report_field("manual_active", 32'(want.manual_active), 32'(got.manual_active));
            if (got.run_changed !== want.run_changed)
                report_field("run_changed", 32'(want.run_changed), 32'(got.run_changed));
        end
    endfunction

    // Input driver: predicts each accepted word, then offers the next one or idles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_status.push_back(control_pass(pass_t'(s_tdata)));
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (!idle_off && $urandom_range(0, 7) == 0) begin
                    tx_gap = $urandom_range(1, 6) - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    s_tdata <= pending_words.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_status(run_status_t'(m_tdata));
            end
            if (long_holds_done != long_holds_req) begin
                long_holds_done++;
                rx_stall = LongHoldCycles;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 7) == 0) begin
                rx_stall = $urandom_range(1, 6) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QuietLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WINDOW_A, REG_WINDOW_B, REG_WINDOW_C: begin
                win_cfg[idx] = value[23:0];
            end
            REG_WINDOW_COUNT: begin
                win_count = value[1:0];
            end
            REG_MANUAL_MINUTES: begin
                run_minutes = value[7:0];
            end
            default: begin
            end
        endcase
    endtask

    // Writes every register; the unused upper bits carry junk.
    task automatic program_schedule(input logic [23:0] ca, input logic [23:0] cb,
                                    input logic [23:0] cc, input logic [1:0] count,
                                    input logic [7:0] minutes);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_WINDOW_A, {junk[31:24], ca});
        write_reg(REG_WINDOW_B, {junk[23:16], cb});
        write_reg(REG_WINDOW_C, {junk[15:8], cc});
        write_reg(REG_WINDOW_COUNT, {junk[29:0], count});
        write_reg(REG_MANUAL_MINUTES, {junk[23:0], minutes});
        @(negedge aclk);
    endtask

    // Holds until every queued word has gone in and every result has come out.
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_status.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic queue_pass(input logic [31:0] ms, input bit ot, input bit btn,
                              input logic [4:0] hr, input logic [5:0] mn, input bit link);
        pass_t p;
        p = '0;
        p.now_ms = ms;
        p.overtemp_low = ot;
        p.button_level = btn;
        p.clock_hour = hr;
        p.clock_minute = mn;
        p.link_up = link;
        pending_words.push_back(p);
    endtask

    function automatic logic [23:0] random_window();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            return {8'($urandom_range(1, 8)), 8'($urandom_range(0, 59)),
                    8'($urandom_range(0, 23))};
        end else if (pick < 9) begin
            return {8'($urandom_range(1, 240)), 8'($urandom_range(0, 59)),
                    8'($urandom_range(0, 23))};
        end
        return 24'($urandom);
    endfunction

    function automatic void set_clock(input int unsigned sec);
        gen_hour = 5'(sec / 3600);
        gen_min = 6'((sec % 3600) / 60);
    endfunction

    // Mostly realistic passes: steady time stamps, clock steered into and past the
    // schedules, occasional presses, link changes and over-temperature spells.
    task automatic queue_random_passes(input int count, input int event_odds);
        int          pick;
        int          idx;
        int unsigned wo;
        int unsigned wc;
        bit          ot;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                gen_ms = $urandom;
            end else if (pick < 15) begin
                gen_ms = gen_ms + 32'($urandom_range(0, 999));
            end else begin
                gen_ms = gen_ms + 32'($urandom_range(1000, 1300));
            end

            pick = $urandom_range(0, 99);
            if (pick < 4 && win_count != 2'd0) begin
                idx = $urandom_range(0, int'(win_count) - 1);
                window_bounds(win_cfg[idx], wo, wc);
                set_clock(wo + $urandom_range(0, wc - wo - 1));
            end else if (pick < 6 && win_count != 2'd0) begin
                idx = $urandom_range(0, int'(win_count) - 1);
                window_bounds(win_cfg[idx], wo, wc);
                set_clock(wc + $urandom_range(0, 120));
            end else if (pick < 8) begin
                gen_hour = 5'($urandom_range(0, 31));
                gen_min = 6'($urandom_range(0, 63));
            end else if (pick < 9) begin
                gen_hour = 5'd0;
                gen_min = 6'd0;
            end else if (pick < 25) begin
                if (gen_min >= 6'd59) begin
                    gen_min = 6'd0;
                    gen_hour = (gen_hour >= 5'd31) ? 5'd0 : gen_hour + 5'd1;
                end else begin
                    gen_min = gen_min + 6'd1;
                end
            end

            if (!gen_btn) begin
                gen_btn = ($urandom_range(0, 1) == 1);
            end else if ($urandom_range(1, event_odds) == 1) begin
                gen_btn = 1'b0;
            end
            if ($urandom_range(1, event_odds / 2) == 1) begin
                gen_link = !gen_link;
            end
            if (gen_ot_left == 0 && $urandom_range(1, event_odds) == 1) begin
                gen_ot_left = $urandom_range(1, 4);
            end
            ot = (gen_ot_left != 0);
            if (gen_ot_left != 0) gen_ot_left--;

            queue_pass(gen_ms, ot, gen_btn, gen_hour, gen_min, gen_link);
        end
    endtask

    initial begin
        reset_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed passes under the reset configuration.
        // Over-temperature timed from a stamp of zero, then a stop while stopped.
        queue_pass(32'd0, 1'b1, 1'b1, 5'd0, 6'd0, 1'b0);
        queue_pass(32'd1000, 1'b1, 1'b1, 5'd0, 6'd0, 1'b0);
        queue_pass(32'd2000, 1'b1, 1'b1, 5'd0, 6'd0, 1'b0);
        queue_pass(32'd2100, 1'b1, 1'b1, 5'd0, 6'd0, 1'b0);
        queue_pass(32'd2200, 1'b0, 1'b1, 5'd0, 6'd0, 1'b0);
        // Manual run from a press, a pass just short of a tick, then a tick.
        queue_pass(32'd3000, 1'b0, 1'b0, 5'd12, 6'd30, 1'b0);
        queue_pass(32'd3999, 1'b0, 1'b0, 5'd12, 6'd30, 1'b0);
        queue_pass(32'd4000, 1'b0, 1'b1, 5'd12, 6'd31, 1'b0);
        // All-ones fields with the link coming up, then a stamp that wraps.
        queue_pass(32'hFFFF_FFFF, 1'b0, 1'b1, 5'd31, 6'd63, 1'b1);
        queue_pass(32'h0000_0100, 1'b1, 1'b1, 5'd23, 6'd59, 1'b1);
        // Over-temperature held after the wrap stops the manual run.
        queue_pass(32'h0000_0900, 1'b1, 1'b1, 5'd23, 6'd59, 1'b1);
        queue_pass(32'h0000_1000, 1'b0, 1'b0, 5'd0, 6'd0, 1'b1);
        queue_pass(32'h0000_1800, 1'b0, 1'b0, 5'd0, 6'd0, 1'b0);
        queue_pass(32'h0000_2000, 1'b0, 1'b1, 5'd0, 6'd0, 1'b1);
        // Press while running stops the run and returns to manual mode.
        queue_pass(32'h0000_2400, 1'b0, 1'b0, 5'd0, 6'd0, 1'b1);
        queue_pass(32'h0000_2800, 1'b0, 1'b1, 5'd16, 6'd32, 1'b0);
        queue_pass(32'hAAAA_AAAA, 1'b0, 1'b1, 5'd10, 6'd21, 1'b0);
        // Press and rising link in the same pass.
        queue_pass(32'h5555_5555, 1'b1, 1'b0, 5'd21, 6'd42, 1'b1);
        wait_idle();

        gen_ms = 32'h5555_6000;
        gen_hour = 5'd6;
        gen_min = 6'd0;
        gen_btn = 1'b0;
        gen_link = 1'b1;
        gen_ot_left = 0;

        // Three random schedules with the shortest manual run.
        program_schedule(random_window(), random_window(), random_window(), 2'd3, 8'd1);
        queue_random_passes(200, 60);
        wait_idle();

        // Raw fields out of range, the longest window, the third schedule unused.
        program_schedule(24'hFF_FFFF, {8'd240, 8'd59, 8'd23}, 24'h00_0000, 2'd2, 8'd240);
        queue_random_passes(150, 60);
        wait_idle();

        // No schedules in use and a zero run length.
        program_schedule(random_window(), random_window(), random_window(), 2'd0, 8'd0);
        queue_random_passes(100, 60);
        wait_idle();

        // One schedule with fallback fields, run length above the limit.
        program_schedule({8'd0, 8'd60, 8'd24}, random_window(), random_window(), 2'd1,
                         8'd241);
        queue_random_passes(150, 60);
        wait_idle();

        // The receiver holds off long enough for the input side to stall.
        program_schedule(random_window(), random_window(), random_window(), 2'd3,
                         8'($urandom_range(1, 240)));
        long_holds_req++;
        queue_random_passes(150, 60);
        wait_idle();

        // Calm closing stretch at full rate so runs can count down to zero.
        program_schedule(random_window(), random_window(), random_window(), 2'd3, 8'd2);
        idle_off = 1'b1;
        queue_random_passes(100, 400);
        wait_idle();

        repeat (DrainCycles) @(posedge aclk);
        if (fail_count == 0 && expected_status.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
